[rtl/assert_macros.svh]
// Assertion macros shared by the checker files.
// Each macro expands to one labelled concurrent assertion on clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked on every clk edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/dcf_pkg.sv]
// Shared constants and types for the delimited command frame matcher.
// No dependencies; imported by the RTL and the checker.
package dcf_pkg;

  localparam int MAX_FRAME_DEF    = 128;
  localparam int NUM_COMMANDS_DEF = 8;

  localparam int BYTE_W     = 8;
  localparam int ENTRY_W    = 3;
  localparam int CHAR_POS_W = 7;
  localparam int IN_USE_W   = 4;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_CHAR     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_CHAR       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMMANDS_IN_USE = 2'd2;

  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'd64;
  localparam logic [BYTE_W-1:0] TAIL_RESET   = 8'd35;
  localparam logic [BYTE_W-1:0] STR_END      = 8'd0;

  // What the compare stage does with a stream byte
  typedef enum logic [1:0] {
    OP_NONE,
    OP_OPEN,
    OP_CMP,
    OP_TAIL
  } frame_op_t;

endpackage

[rtl/delimited_command_frame_matcher.sv]
// Delimited command frame matcher: finds header..tail frames in a byte stream and
// matches the payload against a table of command strings. Uses dcf_pkg and dcf_ram.
//
// One word (stream byte or table character) is taken every cycle unless the input
// stalls. Frame tracking is decided as the word is taken; each command entry has
// its own RAM, read at the current frame position, and the registered read words of
// all entries are compared in parallel in the next cycle. A tail byte's result is
// registered first in the compare stage, then in the output register. Words keep
// flowing while a result waits on the output; the input stalls only when a second
// result is ready behind one not yet taken. The table has no reset: every entry must
// be written, up to and including its zero terminator, before a frame relies on it.
module delimited_command_frame_matcher
  import dcf_pkg::*;
#(
  parameter int MAX_FRAME    = MAX_FRAME_DEF,
  parameter int NUM_COMMANDS = NUM_COMMANDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // input words
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  action,
  input  logic [BYTE_W-1:0]     byte_value,
  input  logic [ENTRY_W-1:0]    entry_select,
  input  logic [CHAR_POS_W-1:0] char_position,
  // results
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  command_found,
  output logic [ENTRY_W-1:0]    command_index,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [BYTE_W-1:0]     cfg_data
);

  localparam int POS_W = $clog2(MAX_FRAME);
  localparam int EXT_W = (POS_W > CHAR_POS_W) ? POS_W : CHAR_POS_W;

  // configuration registers
  logic [BYTE_W-1:0]   header_char;
  logic [BYTE_W-1:0]   tail_char;
  logic [IN_USE_W-1:0] commands_in_use;

  // frame tracking
  logic             in_frame, in_frame_next;
  logic [POS_W-1:0] frame_position, frame_position_next;
  logic             string_ended, string_ended_next;
  frame_op_t        op;

  // compare stage
  logic                    s1_valid;
  frame_op_t               s1_op;
  logic [BYTE_W-1:0]       s1_byte;
  logic                    s1_end_cmp;
  logic                    s1_blocked;
  logic [NUM_COMMANDS-1:0] match_flags;

  logic in_accept, stream_accept, table_write;
  logic pos_room;

  logic [BYTE_W-1:0]       rd [NUM_COMMANDS];
  logic [NUM_COMMANDS-1:0] eq_byte, eq_zero, in_use_mask, hits;
  logic [EXT_W-1:0]        cpos_ext;
  logic                    hit_any;
  logic [ENTRY_W-1:0]      hit_index;
  logic [IN_USE_W:0]       n_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_char     <= HEADER_RESET;
      tail_char       <= TAIL_RESET;
      commands_in_use <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HEADER_CHAR:     header_char     <= cfg_data;
        REG_TAIL_CHAR:       tail_char       <= cfg_data;
        REG_COMMANDS_IN_USE: commands_in_use <= cfg_data[IN_USE_W-1:0];
        default: ;
      endcase
    end
  end

  assign s1_blocked    = s1_valid && (s1_op == OP_TAIL) && out_valid && out_stall;
  assign in_stall      = s1_blocked;
  assign in_accept     = in_valid && !in_stall;
  assign stream_accept = in_accept && !action;

  assign cpos_ext    = EXT_W'(char_position);
  assign table_write = in_accept && action && (32'(entry_select) < NUM_COMMANDS) &&
                       (32'(char_position) < MAX_FRAME);

  assign pos_room = 32'(frame_position) < (MAX_FRAME - 1);

  always_comb begin
    in_frame_next       = in_frame;
    frame_position_next = frame_position;
    string_ended_next   = string_ended;
    op                  = OP_NONE;
    priority if (!in_frame) begin
      if (byte_value == header_char) begin
        in_frame_next       = 1'b1;
        frame_position_next = '0;
        string_ended_next   = 1'b0;
        op                  = OP_OPEN;
      end
    end else if (byte_value == tail_char) begin
      in_frame_next = 1'b0;
      op            = OP_TAIL;
    end else if (byte_value == header_char) begin
      // restart the frame
      frame_position_next = '0;
      string_ended_next   = 1'b0;
      op                  = OP_OPEN;
    end else if (pos_room) begin
      if (!string_ended) begin
        op = OP_CMP;
        if (byte_value == STR_END) begin
          string_ended_next = 1'b1;
        end
      end
      frame_position_next = POS_W'(frame_position + 1'b1);
    end else begin
      // overlong: drop the frame
      in_frame_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      frame_position <= '0;
      string_ended   <= 1'b0;
    end else if (stream_accept) begin
      in_frame       <= in_frame_next;
      frame_position <= frame_position_next;
      string_ended   <= string_ended_next;
    end
  end

  // one table RAM per command entry, all read at the current frame position
  for (genvar e = 0; e < NUM_COMMANDS; e++) begin : g_entry
    dcf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_FRAME)
    ) u_ram (
      .clk   (clk),
      .we    (table_write && (32'(entry_select) == e)),
      .waddr (cpos_ext[POS_W-1:0]),
      .wdata (byte_value),
      .re    (stream_accept),
      .raddr (frame_position),
      .rdata (rd[e])
    );
    assign eq_byte[e]     = (rd[e] == s1_byte);
    assign eq_zero[e]     = (rd[e] == STR_END);
    assign in_use_mask[e] = (32'(e) < 32'(n_eff));
  end

  assign n_eff = (32'(commands_in_use) > NUM_COMMANDS) ?
                 (IN_USE_W + 1)'(NUM_COMMANDS) : {1'b0, commands_in_use};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_blocked) begin
      s1_valid <= stream_accept && (op != OP_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op      <= op;
      s1_byte    <= byte_value;
      s1_end_cmp <= !string_ended;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_flags <= '0;
    end else if (s1_valid) begin
      unique case (s1_op)
        OP_OPEN: match_flags <= '1;
        OP_CMP:  match_flags <= match_flags & eq_byte;
        default: ;
      endcase
    end
  end

  assign hits = (s1_end_cmp ? (match_flags & eq_zero) : match_flags) & in_use_mask;

  always_comb begin
    hit_any   = 1'b0;
    hit_index = '0;
    // scan downwards so the lowest hit wins
    for (int e = NUM_COMMANDS - 1; e >= 0; e--) begin
      if (hits[e]) begin
        hit_any   = 1'b1;
        hit_index = ENTRY_W'(e);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && (s1_op == OP_TAIL) && !s1_blocked) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && (s1_op == OP_TAIL) && !s1_blocked) begin
      command_found <= hit_any;
      command_index <= hit_index;
    end
  end

endmodule

[rtl/dcf_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data while not enabled
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/dcf_checker.sv]
// Port-level checks for the delimited command frame matcher, bound to the top level.
// Depends on dcf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dcf_checker
  import dcf_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  action,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic                  command_found,
  input logic [ENTRY_W-1:0]    command_index
);

  // a stalled result holds
  `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(command_found) && $stable(command_index), "stalled result changed")

  // not-found results carry index zero
  `ASSERT_CLK(a_index_zero, out_valid && !command_found |-> command_index == '0, "not-found result with nonzero index")

  // a fresh result traces back to an accepted stream byte
  `ASSERT_CLK(a_result_cause, $rose(out_valid) |-> $past(in_valid && !in_stall && !action, 2), "result without a tail byte")

endmodule

bind delimited_command_frame_matcher dcf_checker u_dcf_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .action        (action),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .command_found (command_found),
  .command_index (command_index)
);
